/* rtl/vpdc_pkg.sv */
// Shared types, constants and the square-root step for the vector pair classifier.
`timescale 1ns / 1ps
`default_nettype none
package vpdc_pkg;

	// Field widths
	localparam int COMP_W  = 12;
	localparam int DOT_W   = 25;
	localparam int LEN_W   = 24;
	localparam int TOL_W   = 24;
	localparam int SQ_W    = 23;   // one squared component, never negative
	localparam int PROD_W  = 24;   // one signed component product
	localparam int RAD_W   = 48;   // radicand: |a|^2 * |b|^2
	localparam int REM_W   = 26;   // running remainder of the root extraction

	// Root extraction: one result bit per step, a few steps per stage
	localparam int SQRT_STEPS      = RAD_W / 2;
	localparam int STEPS_PER_STAGE = 3;
	localparam int SQRT_STAGES     = SQRT_STEPS / STEPS_PER_STAGE;

	typedef enum logic [2:0] {
		DIR_PERP     = 3'd0,
		DIR_POS_LINE = 3'd1,
		DIR_NEG_LINE = 3'd2,
		DIR_POS      = 3'd3,
		DIR_NEG      = 3'd4
	} dir_class_t;

	typedef enum logic [1:0] {
		SPAT_PARALLEL = 2'd0,
		SPAT_PERP     = 2'd1,
		SPAT_GENERAL  = 2'd2
	} spat_class_t;

	// Partial state of one root extraction
	typedef struct packed {
		logic [RAD_W-1:0] rad;
		logic [REM_W-1:0] rem;
		logic [LEN_W-1:0] root;
	} sqrt_t;

	// One request in flight through the root stages
	typedef struct packed {
		logic                    valid;
		logic signed [DOT_W-1:0] dot;
		sqrt_t                   len;
		sqrt_t                   crs;
	} pipe_t;

	// One restoring digit step: brings down two radicand bits, yields one root bit
	function automatic sqrt_t sqrt_step(input sqrt_t s);
		sqrt_t            r;
		logic [REM_W+1:0] wide;
		logic [REM_W+1:0] trial;
		wide  = {s.rem, s.rad[RAD_W-1 -: 2]};
		trial = {2'b00, s.root, 2'b01};
		r.rad = {s.rad[RAD_W-3:0], 2'b00};
		if (wide >= trial) begin
			r.rem  = REM_W'(wide - trial);
			r.root = {s.root[LEN_W-2:0], 1'b1};
		end else begin
			r.rem  = wide[REM_W-1:0];
			r.root = {s.root[LEN_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/vector_pair_direction_classify_core.sv */
// Top level of the 3D vector pair dot product, length product and orientation classifier.
//
//  channel  direction  signals                              request moved
//  in       sink       in_valid, in_ready, first_*/second_* one pair of 3D vectors
//  out      source     out_valid, out_ready, 4 result ports one classified result
//  cfg      sink       cfg_valid, cfg_ready, tolerance      tolerance register write
//
// One request enters per cycle while the output register is free or taken; each result
// passes 5 front stages, 8 root stages of 3 digit steps each and 1 classify stage.
// All stages advance together whenever the output register is empty or taken.
// A stall on the output holds every stage, so nothing is lost or repeated.
// arst_n clears all valid bits and sets the tolerance to 1.
`timescale 1ns / 1ps
`default_nettype none
module vector_pair_direction_classify_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [vpdc_pkg::COMP_W-1:0]    first_x,
	input  wire logic signed [vpdc_pkg::COMP_W-1:0]    first_y,
	input  wire logic signed [vpdc_pkg::COMP_W-1:0]    first_z,
	input  wire logic signed [vpdc_pkg::COMP_W-1:0]    second_x,
	input  wire logic signed [vpdc_pkg::COMP_W-1:0]    second_y,
	input  wire logic signed [vpdc_pkg::COMP_W-1:0]    second_z,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [vpdc_pkg::DOT_W-1:0]          dot_product,
	output logic [vpdc_pkg::LEN_W-1:0]                 length_product,
	output logic [2:0]                                 direction_class,
	output logic [1:0]                                 spatial_class,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [vpdc_pkg::TOL_W-1:0]            tolerance
);

	localparam int SQRT_STAGES = vpdc_pkg::SQRT_STAGES;

	logic                       adv;
	logic [vpdc_pkg::TOL_W-1:0] tol_q;
	vpdc_pkg::pipe_t            chain [SQRT_STAGES+1];
	vpdc_pkg::dir_class_t       dir;
	vpdc_pkg::spat_class_t      spat;

	// Pipeline moves when the output register is free
	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	// Tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= vpdc_pkg::TOL_W'(1);
		end else if (cfg_valid) begin
			tol_q <= tolerance;
		end
	end

	vpdc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (in_valid),
		.first_x  (first_x),
		.first_y  (first_y),
		.first_z  (first_z),
		.second_x (second_x),
		.second_y (second_y),
		.second_z (second_z),
		.q        (chain[0])
	);

	// Root extraction stages
	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
		vpdc_sqrt_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.d      (chain[g]),
			.q      (chain[g+1])
		);
	end

	vpdc_classify u_classify (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.d       (chain[SQRT_STAGES]),
		.tol     (tol_q),
		.valid_q (out_valid),
		.dot_q   (dot_product),
		.len_q   (length_product),
		.dir_q   (dir),
		.spat_q  (spat)
	);

	assign direction_class = dir;
	assign spatial_class   = spat;

`ifndef ASSERT_OFF
	// Class codes stay within their defined values
	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (direction_class <= vpdc_pkg::DIR_NEG)
			&& (spatial_class <= vpdc_pkg::SPAT_GENERAL))
		else $error("class code out of range");

	// A zero dot product is always perpendicular
	a_zero_dot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (dot_product == '0) |-> (direction_class == vpdc_pkg::DIR_PERP))
		else $error("zero dot product not classed perpendicular");

	// Zero tolerance defeats both strict spatial tests
	a_zero_tol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tol_q == '0) |-> (spatial_class == vpdc_pkg::SPAT_GENERAL))
		else $error("zero tolerance gave a non-general spatial class");

	// Cauchy-Schwarz: a non-negative dot product never exceeds the length product
	a_cauchy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dot_product[vpdc_pkg::DOT_W-1]
			|-> (dot_product[vpdc_pkg::LEN_W-1:0] <= length_product))
		else $error("dot product exceeds length product");
`endif

endmodule
`default_nettype wire

/* rtl/vpdc_front.sv */
// Front end: component products, sums, squared lengths and cross-product radicand.
`timescale 1ns / 1ps
`default_nettype none
module vpdc_front (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 en,
	input  wire logic                                 in_valid,
	input  wire logic signed [vpdc_pkg::COMP_W-1:0]   first_x,
	input  wire logic signed [vpdc_pkg::COMP_W-1:0]   first_y,
	input  wire logic signed [vpdc_pkg::COMP_W-1:0]   first_z,
	input  wire logic signed [vpdc_pkg::COMP_W-1:0]   second_x,
	input  wire logic signed [vpdc_pkg::COMP_W-1:0]   second_y,
	input  wire logic signed [vpdc_pkg::COMP_W-1:0]   second_z,
	output vpdc_pkg::pipe_t                           q
);

	localparam int SQ_W   = vpdc_pkg::SQ_W;
	localparam int PROD_W = vpdc_pkg::PROD_W;
	localparam int DOT_W  = vpdc_pkg::DOT_W;
	localparam int LEN_W  = vpdc_pkg::LEN_W;
	localparam int RAD_W  = vpdc_pkg::RAD_W;
	localparam int REM_W  = vpdc_pkg::REM_W;

	// Stage 1 products
	logic signed [PROD_W-1:0] m_ax, m_ay, m_az, m_bx, m_by, m_bz, m_dx, m_dy, m_dz;

	always_comb begin
		m_ax = PROD_W'(first_x) * PROD_W'(first_x);
		m_ay = PROD_W'(first_y) * PROD_W'(first_y);
		m_az = PROD_W'(first_z) * PROD_W'(first_z);
		m_bx = PROD_W'(second_x) * PROD_W'(second_x);
		m_by = PROD_W'(second_y) * PROD_W'(second_y);
		m_bz = PROD_W'(second_z) * PROD_W'(second_z);
		m_dx = PROD_W'(first_x) * PROD_W'(second_x);
		m_dy = PROD_W'(first_y) * PROD_W'(second_y);
		m_dz = PROD_W'(first_z) * PROD_W'(second_z);
	end

	logic                     valid_s1, valid_s2, valid_s3, valid_s4;
	logic [SQ_W-1:0]          ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1;
	logic signed [PROD_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [LEN_W-1:0]         a2_s2, b2_s2;
	logic signed [DOT_W-1:0]  dot_s2, dot_s3, dot_s4;
	logic [RAD_W-1:0]         p_s3, p_s4, d2_s4;
	logic [LEN_W-1:0]         adot_s3;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Payload stages 1 to 4
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= m_ax[SQ_W-1:0];
			ay_s1 <= m_ay[SQ_W-1:0];
			az_s1 <= m_az[SQ_W-1:0];
			bx_s1 <= m_bx[SQ_W-1:0];
			by_s1 <= m_by[SQ_W-1:0];
			bz_s1 <= m_bz[SQ_W-1:0];
			dx_s1 <= m_dx;
			dy_s1 <= m_dy;
			dz_s1 <= m_dz;

			// squared lengths and dot product
			a2_s2  <= {1'b0, ax_s1} + {1'b0, ay_s1} + {1'b0, az_s1};
			b2_s2  <= {1'b0, bx_s1} + {1'b0, by_s1} + {1'b0, bz_s1};
			dot_s2 <= {dx_s1[PROD_W-1], dx_s1} + {dy_s1[PROD_W-1], dy_s1}
				+ {dz_s1[PROD_W-1], dz_s1};

			// product of squared lengths, magnitude of the dot product
			p_s3    <= RAD_W'(a2_s2) * RAD_W'(b2_s2);
			adot_s3 <= dot_s2[DOT_W-1] ? LEN_W'(-dot_s2) : dot_s2[LEN_W-1:0];
			dot_s3  <= dot_s2;

			// squared dot product
			d2_s4  <= RAD_W'(adot_s3) * RAD_W'(adot_s3);
			p_s4   <= p_s3;
			dot_s4 <= dot_s3;
		end
	end

	// Stage 5: |a x b|^2 = |a|^2 |b|^2 - (a.b)^2, load both root extractions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.valid    <= valid_s4;
			q.dot      <= dot_s4;
			q.len.rad  <= p_s4;
			q.len.rem  <= '0;
			q.len.root <= '0;
			q.crs.rad  <= p_s4 - d2_s4;
			q.crs.rem  <= {REM_W{1'b0}};
			q.crs.root <= {LEN_W{1'b0}};
		end
	end

endmodule
`default_nettype wire

/* rtl/vpdc_sqrt_stage.sv */
// One registered stage of the two parallel root extractions.
`timescale 1ns / 1ps
`default_nettype none
module vpdc_sqrt_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire vpdc_pkg::pipe_t d,
	output vpdc_pkg::pipe_t      q
);

	vpdc_pkg::pipe_t nxt;

	// A few digit steps on each root
	always_comb begin
		nxt = d;
		for (int i = 0; i < vpdc_pkg::STEPS_PER_STAGE; i++) begin
			nxt.len = vpdc_pkg::sqrt_step(nxt.len);
			nxt.crs = vpdc_pkg::sqrt_step(nxt.crs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nxt;
		end
	end

endmodule
`default_nettype wire

/* rtl/vpdc_classify.sv */
// Direction and spatial classification against the tolerance, with the output register.
`timescale 1ns / 1ps
`default_nettype none
module vpdc_classify (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire vpdc_pkg::pipe_t               d,
	input  wire logic [vpdc_pkg::TOL_W-1:0]    tol,
	output logic                               valid_q,
	output logic signed [vpdc_pkg::DOT_W-1:0]  dot_q,
	output logic [vpdc_pkg::LEN_W-1:0]         len_q,
	output vpdc_pkg::dir_class_t               dir_q,
	output vpdc_pkg::spat_class_t              spat_q
);

	localparam int DOT_W = vpdc_pkg::DOT_W;
	localparam int LEN_W = vpdc_pkg::LEN_W;

	logic [LEN_W-1:0]      adot, lenprod, crslen, dl_diff, lc_diff;
	logic                  dot_pos;
	vpdc_pkg::dir_class_t  dir;
	vpdc_pkg::spat_class_t spat;

	always_comb begin
		lenprod = d.len.root;
		crslen  = d.crs.root;
		adot    = d.dot[DOT_W-1] ? LEN_W'(-d.dot) : d.dot[LEN_W-1:0];
		// dot is non-zero wherever the sign is looked at
		dot_pos = !d.dot[DOT_W-1];
		dl_diff = (adot >= lenprod) ? adot - lenprod : lenprod - adot;
		lc_diff = (lenprod >= crslen) ? lenprod - crslen : crslen - lenprod;

		// direction: perpendicular, on the line, or plain sign
		if (adot <= tol)
			dir = vpdc_pkg::DIR_PERP;
		else if (dl_diff <= tol)
			dir = dot_pos ? vpdc_pkg::DIR_POS_LINE : vpdc_pkg::DIR_NEG_LINE;
		else
			dir = dot_pos ? vpdc_pkg::DIR_POS : vpdc_pkg::DIR_NEG;

		// spatial: strict comparisons on the cross length
		if (crslen < tol)
			spat = vpdc_pkg::SPAT_PARALLEL;
		else if (lc_diff < tol)
			spat = vpdc_pkg::SPAT_PERP;
		else
			spat = vpdc_pkg::SPAT_GENERAL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_q  <= d.dot;
			len_q  <= lenprod;
			dir_q  <= dir;
			spat_q <= spat;
		end
	end

endmodule
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the 3D vector pair direction and orientation classifier.
`timescale 1ns / 1ps
module testbench;
	import vpdc_pkg::*;

	localparam int STALL_LIMIT  = 4000;  // cycles with no handshake at all
	localparam int PHASE_PAIRS  = 225;
	localparam int PHASE_COUNT  = 8;
	localparam int TAIL_CYCLES  = 24;    // margin beyond the pipeline depth
	localparam int PRINT_LIMIT  = 60;

	typedef struct packed {
		logic signed [COMP_W-1:0] ax, ay, az;
		logic signed [COMP_W-1:0] bx, by, bz;
	} vec_pair_t;

	typedef struct {
		logic signed [DOT_W-1:0] dot;
		logic [LEN_W-1:0]        len;
		dir_class_t              dir;
		spat_class_t             spat;
	} verdict_t;

	// Predicts the classification of each accepted pair and checks results in order
	class orientation_ledger;
		verdict_t         awaited[$];
		logic [TOL_W-1:0] tol;
		int               errors;
		int               pairs;
		int               checked;
		int               settings;
		int               dir_seen[5];
		int               spat_seen[3];

		function new();
			tol      = 1;
			settings = 1;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// floor of the square root, built one result bit at a time from the top
		function longint unsigned floor_root(longint unsigned n);
			longint unsigned r;
			longint unsigned c;
			r = 0;
			for (int b = 25; b >= 0; b--) begin
				c = r | (64'd1 << b);
				if (c * c <= n)
					r = c;
			end
			return r;
		endfunction

		function longint unsigned gap(longint unsigned a, longint unsigned b);
			return (a >= b) ? a - b : b - a;
		endfunction

		// Note an accepted request and queue its predicted result
		function void take_pair(vec_pair_t p);
			longint          ax, ay, az, bx, by, bz, dot, cx, cy, cz;
			longint unsigned adot, a2, b2, len, c2, crs;
			verdict_t        v;
			ax = $signed(p.ax); ay = $signed(p.ay); az = $signed(p.az);
			bx = $signed(p.bx); by = $signed(p.by); bz = $signed(p.bz);
			dot  = ax * bx + ay * by + az * bz;
			adot = (dot < 0) ? -dot : dot;
			a2   = ax * ax + ay * ay + az * az;
			b2   = bx * bx + by * by + bz * bz;
			len  = floor_root(a2 * b2);
			cx   = ay * bz - az * by;
			cy   = az * bx - ax * bz;
			cz   = ax * by - ay * bx;
			c2   = cx * cx + cy * cy + cz * cz;
			crs  = floor_root(c2);

			// direction: inclusive comparisons against the tolerance
			if (adot <= tol)
				v.dir = DIR_PERP;
			else if (gap(adot, len) <= tol)
				v.dir = (dot > 0) ? DIR_POS_LINE : DIR_NEG_LINE;
			else
				v.dir = (dot > 0) ? DIR_POS : DIR_NEG;

			// orientation: strict comparisons, so zero tolerance always gives general
			if (crs < tol)
				v.spat = SPAT_PARALLEL;
			else if (gap(len, crs) < tol)
				v.spat = SPAT_PERP;
			else
				v.spat = SPAT_GENERAL;

			v.dot = DOT_W'(dot);
			v.len = LEN_W'(len);
			awaited.push_back(v);
			pairs++;
			dir_seen[v.dir]++;
			spat_seen[v.spat]++;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_LIMIT)
				$display("MISMATCH: %s", msg);
		endtask

		// Compare one accepted result with the oldest prediction
		task match_result(logic signed [DOT_W-1:0] dot, logic [LEN_W-1:0] len,
				logic [2:0] dir, logic [1:0] spat);
			verdict_t e;
			if (awaited.size() == 0) begin
				report($sformatf("result (dot %0d) with no request outstanding", dot));
				return;
			end
			e = awaited.pop_front();
			checked++;
			if (dot !== e.dot)
				report($sformatf("result %0d: dot_product %0d, predicted %0d",
					checked, dot, e.dot));
			if (len !== e.len)
				report($sformatf("result %0d: length_product %0d, predicted %0d",
					checked, len, e.len));
			if (dir !== e.dir)
				report($sformatf("result %0d: direction_class %0d, predicted %0d",
					checked, dir, e.dir));
			if (spat !== e.spat)
				report($sformatf("result %0d: spatial_class %0d, predicted %0d",
					checked, spat, e.spat));
		endtask

		task close_out();
			while (awaited.size() != 0) begin
				void'(awaited.pop_front());
				report("predicted result never arrived");
			end
		endtask
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [COMP_W-1:0] first_x, first_y, first_z;
	logic signed [COMP_W-1:0] second_x, second_y, second_z;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [DOT_W-1:0] dot_product;
	logic [LEN_W-1:0]        length_product;
	logic [2:0]              direction_class;
	logic [1:0]              spatial_class;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [TOL_W-1:0]        tolerance;

	orientation_ledger ledger = new;

	vector_pair_direction_classify_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.first_x         (first_x),
		.first_y         (first_y),
		.first_z         (first_z),
		.second_x        (second_x),
		.second_y        (second_y),
		.second_z        (second_z),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.dot_product     (dot_product),
		.length_product  (length_product),
		.direction_class (direction_class),
		.spatial_class   (spatial_class),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.tolerance       (tolerance)
	);

	// 100 MHz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int span(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic vec_pair_t pair_of(int ax, int ay, int az, int bx, int by, int bz);
		vec_pair_t p;
		p.ax = COMP_W'(ax); p.ay = COMP_W'(ay); p.az = COMP_W'(az);
		p.bx = COMP_W'(bx); p.by = COMP_W'(by); p.bz = COMP_W'(bz);
		return p;
	endfunction

	// Present one request and hold it until taken
	task automatic send_pair(vec_pair_t p);
		@(negedge clk);
		first_x  <= p.ax; first_y  <= p.ay; first_z  <= p.az;
		second_x <= p.bx; second_y <= p.by; second_z <= p.bz;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		ledger.take_pair(p);
	endtask

	task automatic idle(int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Stop sending and let every outstanding result come back
	task automatic await_empty();
		@(negedge clk);
		in_valid <= 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_tolerance(logic [TOL_W-1:0] v);
		@(negedge clk);
		tolerance <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		ledger.tol = v;
		ledger.settings++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random pairs, mostly shaped to hit the on-line, perpendicular and zero cases
	task automatic run_items(int count);
		int        a[3], b[3], c[3];
		int        mode, k, lim, gap, pick, calm;
		vec_pair_t p;
		calm = 0;
		for (int n = 0; n < count; n++) begin
			mode = span(0, 99);
			if (mode < 30) begin
				for (int i = 0; i < 3; i++) begin
					a[i] = span(-2048, 2047);
					b[i] = span(-2048, 2047);
				end
			end else if (mode < 40) begin
				for (int i = 0; i < 3; i++) begin
					a[i] = span(-16, 15);
					b[i] = span(-16, 15);
				end
			end else if (mode < 72) begin
				// collinear by a small integer factor, some nudged off the line
				k   = span(1, 5);
				lim = 2047 / k;
				if (span(0, 1) != 0)
					k = -k;
				for (int i = 0; i < 3; i++) begin
					a[i] = span(-lim, lim);
					b[i] = a[i] * k;
					if (mode >= 58) begin
						b[i] += span(-3, 3);
						if (b[i] > 2047)  b[i] = 2047;
						if (b[i] < -2048) b[i] = -2048;
					end
				end
			end else if (mode < 86) begin
				// b = a x c is exactly perpendicular to a
				for (int i = 0; i < 3; i++) begin
					a[i] = span(-40, 40);
					c[i] = span(-25, 25);
				end
				b[0] = a[1] * c[2] - a[2] * c[1];
				b[1] = a[2] * c[0] - a[0] * c[2];
				b[2] = a[0] * c[1] - a[1] * c[0];
			end else if (mode < 93) begin
				pick = span(0, 2);
				for (int i = 0; i < 3; i++) begin
					a[i] = 0;
					b[i] = (pick == 0) ? 0 : span(-2048, 2047);
				end
			end else begin
				for (int i = 0; i < 3; i++) begin
					pick = span(0, 6);
					a[i] = (pick == 0) ? -2048 : (pick == 1) ? -2047 : (pick == 2) ? -1 :
						(pick == 3) ? 0 : (pick == 4) ? 1 : (pick == 5) ? 2046 : 2047;
					pick = span(0, 6);
					b[i] = (pick == 0) ? -2048 : (pick == 1) ? -2047 : (pick == 2) ? -1 :
						(pick == 3) ? 0 : (pick == 4) ? 1 : (pick == 5) ? 2046 : 2047;
				end
			end
			if (span(0, 1) != 0)
				p = pair_of(b[0], b[1], b[2], a[0], a[1], a[2]);
			else
				p = pair_of(a[0], a[1], a[2], b[0], b[1], b[2]);
			send_pair(p);

			// sender gaps: mostly none or short, a few long, occasional bursts
			if (calm > 0) begin
				calm--;
				gap = 0;
			end else begin
				pick = span(0, 99);
				if (pick < 3) begin
					calm = span(30, 100);
					gap  = 0;
				end else if (pick < 55)
					gap = 0;
				else if (pick < 88)
					gap = span(1, 3);
				else if (pick < 98)
					gap = span(4, 12);
				else
					gap = span(20, 40);
			end
			idle(gap);
		end
	endtask

	// Result sink with random back-pressure
	initial begin
		int hold, calm, pick;
		out_ready = 1'b0;
		hold = 0;
		calm = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else if (calm > 0) begin
				out_ready <= 1'b1;
				calm--;
			end else begin
				pick = span(0, 99);
				if (pick < 5) begin
					calm = span(40, 150);
					out_ready <= 1'b1;
				end else if (pick < 60) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					if (pick < 90)
						hold = span(0, 2);
					else if (pick < 98)
						hold = span(3, 12);
					else
						hold = span(20, 60);
				end
			end
		end
	end

	// Check each result as it is taken
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.match_result(dot_product, length_product, direction_class,
				spatial_class);
	end

	// Watchdog: ends the run when no channel moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
			quiet, ledger.pending());
		$display("TEST FAILED");
		$finish;
	end

	// Main sequence
	initial begin
		logic [TOL_W-1:0] setting[PHASE_COUNT];
		vec_pair_t        directed[$];
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		first_x   = '0; first_y  = '0; first_z  = '0;
		second_x  = '0; second_y = '0; second_z = '0;
		cfg_valid = 1'b0;
		tolerance = '0;

		// first phase runs on the reset value; the rest are written
		setting[0] = 24'd1;
		setting[1] = 24'd0;
		setting[2] = 24'hFFFFFF;
		setting[3] = 24'd2;
		setting[4] = 24'd30;
		setting[5] = 24'd800;
		setting[6] = 24'd60000;
		setting[7] = TOL_W'($urandom_range(24'hFFFFFF));

		directed.push_back(pair_of(0, 0, 0, 0, 0, 0));               // both zero
		directed.push_back(pair_of(0, 0, 0, 5, -7, 9));              // one zero
		directed.push_back(pair_of(1, 0, 0, 0, 1, 0));               // axes at right angle
		directed.push_back(pair_of(1, 0, 0, 1, 0, 0));               // same unit vector
		directed.push_back(pair_of(3, 0, 0, -5, 0, 0));              // opposite
		directed.push_back(pair_of(2047, 2047, 2047, 2047, 2047, 2047));
		directed.push_back(pair_of(-2048, -2048, -2048, -2048, -2048, -2048)); // largest dot
		directed.push_back(pair_of(-2048, -2048, -2048, 2047, 2047, 2047));    // most negative
		directed.push_back(pair_of(2047, 0, 0, 0, 0, -2048));
		directed.push_back(pair_of(-2048, 2047, -2048, 2047, -2048, 2047));
		directed.push_back(pair_of(1, 2, 3, 4, 5, 6));
		directed.push_back(pair_of(1, 0, 0, 1, 1, 0));               // 45 degrees
		directed.push_back(pair_of(1, 0, 0, 1, 5, 0));               // dot within tolerance
		directed.push_back(pair_of(100, 200, -300, -200, -400, 600)); // scaled opposite
		directed.push_back(pair_of(-1, -1, -1, 1, 1, 1));
		directed.push_back(pair_of(2047, -2048, 1, -1, 0, 2047));
		directed.push_back(pair_of(12, -5, 0, 5, 12, 7));            // zero dot, nonzero vectors

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			if (ph > 0) begin
				await_empty();
				write_tolerance(setting[ph]);
			end else begin
				foreach (directed[i]) begin
					send_pair(directed[i]);
					idle(span(0, 2));
				end
			end
			run_items(PHASE_PAIRS);
		end

		await_empty();
		repeat (TAIL_CYCLES) @(posedge clk);
		ledger.close_out();

		$display("Covered %0d vector pairs under %0d tolerance settings, %0d results checked.",
			ledger.pairs, ledger.settings, ledger.checked);
		$display("Direction classes %0d/%0d/%0d/%0d/%0d, spatial classes %0d/%0d/%0d.",
			ledger.dir_seen[0], ledger.dir_seen[1], ledger.dir_seen[2],
			ledger.dir_seen[3], ledger.dir_seen[4],
			ledger.spat_seen[0], ledger.spat_seen[1], ledger.spat_seen[2]);
		if (ledger.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
